// ----- rtl/prs_pkg.sv -----
// Shared constants, codes and types of the per-class reservoir sampler.
`default_nettype none

package prs_pkg;

    // Default sizes handed to the top level.
    localparam int NUM_CLASSES_DEF  = 16;
    localparam int MAX_ROWS_DEF     = 64;
    localparam int FEATURE_LEN_DEF  = 16;
    localparam int FEATURE_BITS_DEF = 16;

    // Beat field widths.
    localparam int OP_W      = 2;
    localparam int LABEL_W   = 4;
    localparam int VALUE_W   = 16;
    localparam int RANDOM_W  = 32;
    localparam int ROWIDX_W  = 6;
    localparam int ELEMIDX_W = 4;
    localparam int ROWS_W    = 7;
    localparam int COUNT_W   = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int NCLS_W     = 5;
    localparam int MAXS_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLES = 1'd1;

    localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = 5'd16;
    localparam logic [MAXS_W-1:0] MAX_SAMPLES_RST = 7'd64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // Request to the modulo unit.
    typedef struct packed {
        logic                 start;
        logic [RANDOM_W-1:0]  dividend;
        logic [COUNT_W:0]     divisor;
    } div_req_t;

    // One result beat.
    typedef struct packed {
        logic [ROWS_W-1:0]         stored_rows;
        logic [COUNT_W-1:0]        input_count;
        logic                      element_stored;
        logic                      sample_done;
        logic signed [VALUE_W-1:0] read_value;
        logic                      error_flag;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/prs_sample_if.sv -----
// Input channel of the reservoir sampler: one operation per beat.
`default_nettype none

interface prs_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [prs_pkg::OP_W-1:0]             op;
    logic [prs_pkg::LABEL_W-1:0]          class_label;
    logic signed [prs_pkg::VALUE_W-1:0]   feature_value;
    logic                                 last_element;
    logic [prs_pkg::RANDOM_W-1:0]         random_word;
    logic [prs_pkg::ROWIDX_W-1:0]         row_index;
    logic [prs_pkg::ELEMIDX_W-1:0]        element_index;

    modport source (
        output valid, op, class_label, feature_value, last_element,
               random_word, row_index, element_index,
        input  ready
    );

    modport sink (
        input  valid, op, class_label, feature_value, last_element,
               random_word, row_index, element_index,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/prs_result_if.sv -----
// Output channel of the reservoir sampler: one result per beat.
`default_nettype none

interface prs_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [prs_pkg::ROWS_W-1:0]           stored_rows;
    logic [prs_pkg::COUNT_W-1:0]          input_count;
    logic                                 element_stored;
    logic                                 sample_done;
    logic signed [prs_pkg::VALUE_W-1:0]   read_value;
    logic                                 error_flag;

    modport source (
        output valid, stored_rows, input_count, element_stored, sample_done,
               read_value, error_flag,
        input  ready
    );

    modport sink (
        input  valid, stored_rows, input_count, element_stored, sample_done,
               read_value, error_flag,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/per_class_reservoir_sampler.sv -----
// Top level of the per-class reservoir sampler: control, count store, sample store.
//
//   channel   dir   handshake        payload
//   sample    in    valid / ready    op, class_label, feature_value, last_element,
//                                    random_word, row_index, element_index
//   result    out   valid / ready    stored_rows, input_count, element_stored,
//                                    sample_done, read_value, error_flag
//   cfg       in    cfg_we           cfg_index, cfg_data (no read-back)
//
// Operation: one operation at a time. Most beats are accepted with the RAM
// read, then evaluated and written back. The first element of a sample whose
// class reservoir is full also has the slot pick run the remainder of
// random_word by (input count + 1) through the radix-2 unit.
// Reset: count valid bits clear, so every class reads as empty; no clearing pass.
// Stalls: the next beat is taken while a result waits in the output register;
// a finished beat holds in its last state until that register frees up.
`default_nettype none

module per_class_reservoir_sampler #(
    parameter int NUM_CLASSES  = prs_pkg::NUM_CLASSES_DEF,
    parameter int MAX_ROWS     = prs_pkg::MAX_ROWS_DEF,
    parameter int FEATURE_LEN  = prs_pkg::FEATURE_LEN_DEF,
    parameter int FEATURE_BITS = prs_pkg::FEATURE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    prs_sample_if.sink                               sample,
    prs_result_if.source                             result,
    input  wire logic                                cfg_we,
    input  wire logic [prs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [prs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int POS_W  = (FEATURE_LEN > 1) ? $clog2(FEATURE_LEN) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int POSC_W = $clog2(FEATURE_LEN + 1);
    localparam int CNT_W  = prs_pkg::COUNT_W;
    localparam int CREC_W = RCNT_W + CNT_W;
    localparam int SA_W   = CLS_W + ROW_W + POS_W;
    localparam int STORE_DEPTH = NUM_CLASSES * (1 << (ROW_W + POS_W));

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Latched beat.
    logic [prs_pkg::OP_W-1:0]       op_reg;
    logic [prs_pkg::LABEL_W-1:0]    label_reg;
    logic [FEATURE_BITS-1:0]        value_reg;
    logic                           last_reg;
    logic [prs_pkg::RANDOM_W-1:0]   rnd_reg;
    logic [prs_pkg::ROWIDX_W-1:0]   row_reg;
    logic [prs_pkg::ELEMIDX_W-1:0]  elem_reg;

    // Configuration.
    logic [prs_pkg::NCLS_W-1:0]     num_classes_reg;
    logic [prs_pkg::MAXS_W-1:0]     max_samples_reg;

    // Open-sample state.
    logic [POSC_W-1:0]              pos_reg;
    logic [ROW_W-1:0]               tgt_reg;
    logic                           en_reg;
    logic [CLS_W-1:0]               sample_class_reg;

    // Per-class count valid bits; a clear entry reads as zero counts.
    logic [NUM_CLASSES-1:0]         vld_reg;
    logic                           vld_q_reg;

    // Memories.
    logic                           accept;
    logic [CLS_W-1:0]               cnt_raddr;
    logic [CREC_W-1:0]              cnt_rdata;
    logic                           cnt_we;
    logic [CREC_W-1:0]              cnt_wdata;
    logic [SA_W-1:0]                st_raddr;
    logic [SA_W-1:0]                st_waddr;
    logic [FEATURE_BITS-1:0]        st_rdata;
    logic                           st_we;

    // Modulo unit.
    prs_pkg::div_req_t              div_req;
    logic                           div_done;
    logic [prs_pkg::RANDOM_W-1:0]   div_rem;

    // Evaluation.
    logic [RCNT_W-1:0]              rows_rd;
    logic [CNT_W-1:0]               cnt_rd;
    logic [RCNT_W-1:0]              cap;
    logic [RCNT_W-1:0]              rows_new;
    logic [CNT_W-1:0]               cnt_new;
    logic                           label_ok;
    logic                           first;
    logic                           k_ok;
    logic                           need_div;
    logic                           add_ok;
    logic                           store_ok;
    logic                           rows_inc;
    logic                           eff_en;
    logic [ROW_W-1:0]               eff_tgt;
    logic [CLS_W-1:0]               eff_cls;
    logic                           out_free;
    logic                           commit;
    logic                           abandon;
    prs_pkg::result_t               res;

    // Output register.
    logic                           out_valid_reg;
    prs_pkg::result_t               out_reg;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    // Addresses: beat fields or the open sample's class, so data is ready in S_EVAL.
    assign cnt_raddr = (sample.op == prs_pkg::OP_ADD && pos_reg != '0)
                       ? sample_class_reg : CLS_W'(sample.class_label);
    assign st_raddr  = {CLS_W'(sample.class_label), ROW_W'(sample.row_index),
                        POS_W'(sample.element_index)};

    prs_ram #(
        .WIDTH (CREC_W),
        .DEPTH (NUM_CLASSES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (eff_cls),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    prs_ram #(
        .WIDTH (FEATURE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (value_reg),
        .re    (accept),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    prs_modulo u_modulo (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Counts of the addressed class; an invalid entry means released or never used.
    assign rows_rd = vld_q_reg ? cnt_rdata[CREC_W-1 -: RCNT_W] : '0;
    assign cnt_rd  = vld_q_reg ? cnt_rdata[CNT_W-1:0] : '0;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        label_ok = (32'(label_reg) < 32'(num_classes_reg))
                   && (32'(label_reg) < NUM_CLASSES);
        cap      = (32'(max_samples_reg) < MAX_ROWS) ? RCNT_W'(max_samples_reg)
                                                       : RCNT_W'(MAX_ROWS);
        first    = (pos_reg == '0);
        k_ok     = div_rem < prs_pkg::RANDOM_W'(cap);
        eff_cls  = first ? CLS_W'(label_reg) : sample_class_reg;

        // Slot choice: from the remainder after a pick, else append, else the open sample.
        if (state_reg == S_FIN)
        begin
            eff_en  = k_ok;
            eff_tgt = k_ok ? ROW_W'(div_rem) : '0;
        end
        else if (first)
        begin
            eff_en  = 1'b1;
            eff_tgt = ROW_W'(rows_rd);
        end
        else
        begin
            eff_en  = en_reg;
            eff_tgt = tgt_reg;
        end

        add_ok   = (op_reg == prs_pkg::OP_ADD) && !(first && !label_ok);
        need_div = add_ok && first && !(rows_rd < cap);
        store_ok = eff_en && (32'(pos_reg) < FEATURE_LEN);
        rows_inc = eff_en && (32'(eff_tgt) == 32'(rows_rd)) && (32'(rows_rd) < MAX_ROWS);
        rows_new = rows_inc ? rows_rd + RCNT_W'(1) : rows_rd;
        cnt_new  = (&cnt_rd) ? cnt_rd : cnt_rd + CNT_W'(1);

        commit   = out_free && (((state_reg == S_EVAL) && !need_div)
                                || (state_reg == S_FIN));
        abandon  = (op_reg == prs_pkg::OP_RELEASE) && label_ok && !first
                   && (sample_class_reg == CLS_W'(label_reg));

        res = '0;
        unique case (op_reg)
            prs_pkg::OP_ADD:
            begin
                if (!add_ok)
                begin
                    res.error_flag = 1'b1;
                end
                else
                begin
                    res.element_stored = store_ok;
                    res.sample_done    = last_reg;
                    res.stored_rows    = prs_pkg::ROWS_W'(last_reg ? rows_new : rows_rd);
                    res.input_count    = last_reg ? cnt_new : cnt_rd;
                end
            end
            prs_pkg::OP_RELEASE:
            begin
                res.error_flag = !label_ok;
            end
            prs_pkg::OP_READ:
            begin
                if (!label_ok)
                begin
                    res.error_flag = 1'b1;
                end
                else
                begin
                    res.stored_rows = prs_pkg::ROWS_W'(rows_rd);
                    res.input_count = cnt_rd;
                    if ((32'(row_reg) < 32'(rows_rd)) && (32'(row_reg) < MAX_ROWS)
                        && (32'(elem_reg) < FEATURE_LEN))
                    begin
                        res.read_value = prs_pkg::VALUE_W'(st_rdata);
                    end
                    else
                    begin
                        res.error_flag = 1'b1;
                    end
                end
            end
            default:
            begin
                res.error_flag = 1'b1;
            end
        endcase
    end

    // Write-back of the element and, on the last one, of the class counts.
    assign st_we     = commit && add_ok && store_ok;
    assign st_waddr  = {eff_cls, eff_tgt, POS_W'(pos_reg)};
    assign cnt_we    = commit && add_ok && last_reg;
    assign cnt_wdata = {rows_new, cnt_new};

    assign div_req.start    = (state_reg == S_EVAL) && need_div;
    assign div_req.dividend = rnd_reg;
    assign div_req.divisor  = (CNT_W + 1)'(cnt_rd) + (CNT_W + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (need_div)
                begin
                    state_next = S_DIV;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_classes_reg  <= prs_pkg::NUM_CLASSES_RST;
            max_samples_reg  <= prs_pkg::MAX_SAMPLES_RST;
            pos_reg          <= '0;
            tgt_reg          <= '0;
            en_reg           <= 1'b0;
            sample_class_reg <= '0;
            vld_reg          <= '0;
            vld_q_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    prs_pkg::REG_NUM_CLASSES:
                        num_classes_reg <= prs_pkg::NCLS_W'(cfg_data);
                    prs_pkg::REG_MAX_SAMPLES:
                        max_samples_reg <= prs_pkg::MAXS_W'(cfg_data);
                    default:
                        max_samples_reg <= max_samples_reg;
                endcase
            end

            if (accept)
            begin
                vld_q_reg <= (32'(cnt_raddr) < NUM_CLASSES) ? vld_reg[cnt_raddr] : 1'b0;
            end

            if (commit && add_ok)
            begin
                sample_class_reg <= eff_cls;
                if (last_reg)
                begin
                    // Close the sample.
                    pos_reg          <= '0;
                    en_reg           <= 1'b0;
                    tgt_reg          <= '0;
                    vld_reg[eff_cls] <= 1'b1;
                end
                else
                begin
                    // Advance, saturating at the vector length.
                    if (32'(pos_reg) < FEATURE_LEN)
                    begin
                        pos_reg <= pos_reg + POSC_W'(1);
                    end
                    en_reg  <= eff_en;
                    tgt_reg <= eff_tgt;
                end
            end

            if (commit && (op_reg == prs_pkg::OP_RELEASE) && label_ok)
            begin
                // Drop the class counts; abandon its open sample.
                vld_reg[CLS_W'(label_reg)] <= 1'b0;
                if (abandon)
                begin
                    pos_reg <= '0;
                    en_reg  <= 1'b0;
                    tgt_reg <= '0;
                end
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= sample.op;
            label_reg <= sample.class_label;
            value_reg <= FEATURE_BITS'(sample.feature_value);
            last_reg  <= sample.last_element;
            rnd_reg   <= sample.random_word;
            row_reg   <= sample.row_index;
            elem_reg  <= sample.element_index;
        end
        if (commit)
        begin
            out_reg <= res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.stored_rows    = out_reg.stored_rows;
    assign result.input_count    = out_reg.input_count;
    assign result.element_stored = out_reg.element_stored;
    assign result.sample_done    = out_reg.sample_done;
    assign result.read_value     = out_reg.read_value;
    assign result.error_flag     = out_reg.error_flag;

endmodule

`default_nettype wire

// ----- rtl/prs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prs_ram #(
    parameter int WIDTH = prs_pkg::FEATURE_BITS_DEF,
    parameter int DEPTH = prs_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/prs_modulo.sv -----
// Radix-2 restoring remainder unit: one quotient bit per cycle.
`default_nettype none

module prs_modulo (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire prs_pkg::div_req_t               req,
    output logic                                 done,
    output logic [prs_pkg::RANDOM_W-1:0]         remainder
);

    localparam int STEPS   = prs_pkg::RANDOM_W;
    localparam int STEP_W  = $clog2(STEPS);

    logic                              busy_reg;
    logic                              done_reg;
    logic [STEP_W-1:0]                 step_reg;
    logic [prs_pkg::RANDOM_W-1:0]      rem_reg;
    logic [prs_pkg::RANDOM_W-1:0]      rem_next;
    logic [prs_pkg::RANDOM_W-1:0]      dvd_reg;
    logic [prs_pkg::COUNT_W:0]         dsr_reg;
    logic [prs_pkg::RANDOM_W:0]        shifted;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[prs_pkg::RANDOM_W-1]};
        if (shifted >= dsr_reg)
        begin
            rem_next = prs_pkg::RANDOM_W'(shifted - dsr_reg);
        end
        else
        begin
            rem_next = shifted[prs_pkg::RANDOM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[prs_pkg::RANDOM_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
